// ===== rtl/core/rotation_transform_matrix_unit_core_assert.svh =====
// ----------------------------------------------------------------------------
// rotation transform matrix unit assertion macros
// shared concurrent assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ROTATION_TRANSFORM_MATRIX_UNIT_CORE_ASSERT_SVH
`define ROTATION_TRANSFORM_MATRIX_UNIT_CORE_ASSERT_SVH
`ifndef SYNTH
`define RTMU_ASSERT_IMPL(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define RTMU_ASSERT_PAST(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) 1'b1 |=> prop) \
    else $error("assertion failed");
`else
`define RTMU_ASSERT_IMPL(lbl, clk, rstn, prop)
`define RTMU_ASSERT_PAST(lbl, clk, rstn, prop)
`endif
`endif

// ===== rtl/core/rtmu_pkg.sv =====
// ----------------------------------------------------------------------------
// rtmu_pkg
// shared types, opcodes and trig table for the rotation transform matrix unit
// ----------------------------------------------------------------------------
package rtmu_pkg;

  localparam int unsigned OpW = 3;

  typedef enum logic [2:0] {
    OP_IDENT  = 3'd0,
    OP_ZERO   = 3'd1,
    OP_ROT_X  = 3'd2,
    OP_ROT_Y  = 3'd3,
    OP_ROT_Z  = 3'd4,
    OP_XFORM  = 3'd5,
    OP_RSVD6  = 3'd6,
    OP_RSVD7  = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRIG,
    ST_READ,
    ST_ROW,
    ST_MAC,
    ST_WRITE,
    ST_OUT,
    ST_CLEAR
  } state_e;

  // q2.14 sine over a quarter turn, index r in 0..256 at 1024 steps a turn
  function automatic logic signed [15:0] qsin(input int r, input int s);
    real x;
    real v;
    begin
      // pi/2 * r, then scaled down by 2^s
      x = 1.57079632679489661923 * real'(r);
      for (int i = 0; i < s; i++) x = x * 0.5;
      v = 16384.0 * $sin(x);
      qsin = 16'(int'($floor(v + 0.5)));
    end
  endfunction

endpackage

// ===== rtl/core/rtmu_trig.sv =====
// ----------------------------------------------------------------------------
// rtmu_trig
// registered sine and cosine lookup, scaled to the matrix fraction width
// ----------------------------------------------------------------------------
module rtmu_trig #(
  parameter int ANGLE_BITS = 10,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic [ANGLE_BITS-1:0] angle_i,
  output logic signed [31:0]    sin_o,
  output logic signed [31:0]    cos_o
);

  localparam int S     = ANGLE_BITS - 2;
  localparam int Q4    = 1 << S;
  localparam int UpSh  = (FRAC_BITS >= 14) ? FRAC_BITS - 14 : 0;
  localparam int DnSh  = (FRAC_BITS < 14) ? 14 - FRAC_BITS : 0;

  logic signed [15:0] tab [Q4+1];

  for (genvar g = 0; g <= Q4; g++) begin : g_tab
    localparam logic signed [15:0] TabVal = rtmu_pkg::qsin(g, S);
    assign tab[g] = TabVal;
  end

  function automatic logic signed [31:0] lookup(input logic [ANGLE_BITS-1:0] k);
    logic [1:0]   q;
    logic [S:0]   r;
    logic signed [31:0] f;
    begin
      q = k[ANGLE_BITS-1 -: 2];
      r = {1'b0, k[S-1:0]};
      if (q[0]) r = (S+1)'(Q4) - r;
      f = 32'(tab[r]);
      if (q[1]) f = -f;
      lookup = (f <<< UpSh) >>> DnSh;
    end
  endfunction

  logic [ANGLE_BITS-1:0] cos_k;
  assign cos_k = angle_i + ANGLE_BITS'(Q4);

  always_ff @(posedge clk_i) begin
    sin_o <= lookup(angle_i);
    cos_o <= lookup(cos_k);
  end

endmodule

// ===== rtl/core/rtmu_lanes.sv =====
// ----------------------------------------------------------------------------
// rtmu_lanes
// four multiply lanes, floored product and saturating row sum
// ----------------------------------------------------------------------------
module rtmu_lanes #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic signed [31:0] a_i [4],
  input  logic signed [31:0] b_i [4],
  output logic signed [31:0] sum_o,
  output logic               clip_o
);

  logic signed [63:0] prod_q [4];
  logic signed [65:0] acc;

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 4; l++) begin
      prod_q[l] <= (64'(a_i[l]) * 64'(b_i[l])) >>> FRAC_BITS;
    end
  end

  always_comb begin
    acc = 66'(prod_q[0]) + 66'(prod_q[1]) + 66'(prod_q[2]) + 66'(prod_q[3]);
    clip_o = 1'b0;
    sum_o  = acc[31:0];
    if (acc > 66'sh7fffffff) begin
      sum_o = 32'sh7fffffff; clip_o = 1'b1;
    end else if (acc < -66'sh80000000) begin
      sum_o = 32'sh80000000; clip_o = 1'b1;
    end
  end

endmodule

// ===== rtl/core/rotation_transform_matrix_unit_core.sv =====
// ----------------------------------------------------------------------------
// rotation_transform_matrix_unit_core
// 4x4 q16.16 transform matrix held in a row memory, rotate and transform
// ----------------------------------------------------------------------------
// usage: words arrive on s_axis (opcode, angle, vector). opcodes 0 and 1 load
// identity or zero, 2..4 multiply the matrix on the right by a rotation about
// x, y or z, 5 returns matrix times vector on m_axis, 6 and 7 do nothing.
// the matrix sits in a 4-row memory with a registered read; for a rotation one
// row at a time is read, run through four multiply lanes and written back.
// load opcodes write the four rows in turn; rotations run a trig lookup, then
// per row a read, four column passes and a drain before the write-back;
// transforms read each row in turn, then pass the result to m_axis.
// one word is in work at a time; s_axis_tready is high only while idle.
// after reset a clearing pass writes the identity, s_axis_tready low.
// when the receiver stalls the result holds in the output register; matrix
// opcodes keep running, and a following transform waits in its last cycle
// until the output register is free.
// ----------------------------------------------------------------------------
`include "rotation_transform_matrix_unit_core_assert.svh"
module rotation_transform_matrix_unit_core #(
  parameter int ANGLE_BITS = 10,
  parameter int FRAC_BITS  = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // opcode[2:0], angle[12:3], vec_x[44:13], vec_y[76:45], vec_z[108:77],
  // vec_w[140:109], zero fill
  input  logic [143:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_x[31:0], out_y[63:32], out_z[95:64], out_w[127:96], saturated[128]
  output logic [135:0] m_axis_tdata
);

  localparam logic signed [31:0] One = 32'sd1 <<< FRAC_BITS;

  rtmu_pkg::state_e state_q, state_d;
  logic [rtmu_pkg::OpW-1:0] op_q;
  logic [ANGLE_BITS-1:0] ang_q;
  logic signed [31:0] vec_q [4];
  logic [1:0] row_q, row_d;
  logic [1:0] cnt_q, cnt_d;
  logic signed [31:0] res_q [4];
  logic clip_q;
  logic out_v_q;
  logic [135:0] out_q;
  logic out_ld;

  // row memory
  logic [127:0] mem [4];
  logic [127:0] rd_q;
  logic         we;
  logic [1:0]   wa;
  logic [127:0] wd;
  logic [1:0]   ra;

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  logic signed [31:0] sin_w, cos_w;
  rtmu_trig #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_trig (
    .clk_i(clk_i), .angle_i(ang_q), .sin_o(sin_w), .cos_o(cos_w));

  // rotation column cnt_q
  logic signed [31:0] rcol [4];
  always_comb begin
    for (int t = 0; t < 4; t++) rcol[t] = (32'(t) == 32'(cnt_q)) ? One : 32'sd0;
    unique case (rtmu_pkg::op_e'(op_q))
      rtmu_pkg::OP_ROT_X: begin
        if (cnt_q == 2'd1) begin rcol[1] = cos_w; rcol[2] = -sin_w; end
        if (cnt_q == 2'd2) begin rcol[1] = sin_w; rcol[2] = cos_w; end
      end
      rtmu_pkg::OP_ROT_Y: begin
        if (cnt_q == 2'd0) begin rcol[0] = cos_w; rcol[2] = sin_w; end
        if (cnt_q == 2'd2) begin rcol[0] = -sin_w; rcol[2] = cos_w; end
      end
      rtmu_pkg::OP_ROT_Z: begin
        if (cnt_q == 2'd0) begin rcol[0] = cos_w; rcol[1] = -sin_w; end
        if (cnt_q == 2'd1) begin rcol[0] = sin_w; rcol[1] = cos_w; end
      end
      default: ;
    endcase
  end

  logic signed [31:0] row_a [4];
  logic signed [31:0] lane_b [4];
  logic signed [31:0] sum_w;
  logic clip_w;
  logic xform;
  assign xform = (op_q == rtmu_pkg::OP_XFORM);
  always_comb begin
    for (int t = 0; t < 4; t++) begin
      row_a[t]  = rd_q[32*t +: 32];
      lane_b[t] = xform ? vec_q[t] : rcol[t];
    end
  end

  rtmu_lanes #(.FRAC_BITS(FRAC_BITS)) u_lanes (
    .clk_i(clk_i), .a_i(row_a), .b_i(lane_b), .sum_o(sum_w), .clip_o(clip_w));

  // for a rotation the row word is held in rd_q while its four columns go
  // through the lanes (the mac stage takes the lane result in the next cycle)
  logic [1:0] mac_idx_q;
  logic       mac_v_q;

  // result moves to the output register once the previous word is gone
  assign out_ld = (state_q == rtmu_pkg::ST_OUT) && (!out_v_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    cnt_d   = cnt_q;
    we = 1'b0; wa = row_q; wd = '0;
    ra = xform ? cnt_q : row_q;
    s_axis_tready = 1'b0;
    unique case (state_q)
      rtmu_pkg::ST_CLEAR: begin
        we = 1'b1;
        wd = 128'(One) << (32 * row_q);
        row_d = row_q + 2'd1;
        if (row_q == 2'd3) state_d = rtmu_pkg::ST_IDLE;
      end
      rtmu_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        row_d = '0; cnt_d = '0;
        if (s_axis_tvalid) begin
          unique case (rtmu_pkg::op_e'(s_axis_tdata[2:0]))
            rtmu_pkg::OP_IDENT, rtmu_pkg::OP_ZERO: state_d = rtmu_pkg::ST_WRITE;
            rtmu_pkg::OP_ROT_X, rtmu_pkg::OP_ROT_Y, rtmu_pkg::OP_ROT_Z:
              state_d = rtmu_pkg::ST_TRIG;
            rtmu_pkg::OP_XFORM: state_d = rtmu_pkg::ST_READ;
            default: state_d = rtmu_pkg::ST_IDLE;
          endcase
        end
      end
      rtmu_pkg::ST_WRITE: begin
        we = 1'b1;
        wd = (op_q == rtmu_pkg::OP_IDENT) ? 128'(One) << (32 * row_q) : '0;
        row_d = row_q + 2'd1;
        if (row_q == 2'd3) state_d = rtmu_pkg::ST_IDLE;
      end
      rtmu_pkg::ST_TRIG: state_d = rtmu_pkg::ST_READ;
      rtmu_pkg::ST_READ: state_d = rtmu_pkg::ST_ROW;
      rtmu_pkg::ST_ROW: begin
        // cnt_q steps columns (rotate) or rows (transform, memory reread)
        cnt_d = cnt_q + 2'd1;
        if (xform) ra = cnt_d;
        if (cnt_q == 2'd3) state_d = rtmu_pkg::ST_MAC;
        else if (xform) state_d = rtmu_pkg::ST_READ;
      end
      rtmu_pkg::ST_MAC: begin
        if (!mac_v_q) begin
          if (xform) state_d = rtmu_pkg::ST_OUT;
          else begin
            we = 1'b1;
            wd = {res_q[3], res_q[2], res_q[1], res_q[0]};
            row_d = row_q + 2'd1;
            cnt_d = '0;
            ra = row_d;
            state_d = (row_q == 2'd3) ? rtmu_pkg::ST_IDLE : rtmu_pkg::ST_READ;
          end
        end
      end
      rtmu_pkg::ST_OUT: begin
        if (!out_v_q || m_axis_tready) state_d = rtmu_pkg::ST_IDLE;
      end
      default: state_d = rtmu_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rtmu_pkg::ST_CLEAR;
      row_q <= '0; cnt_q <= '0;
      mac_v_q <= 1'b0; mac_idx_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q <= row_d; cnt_q <= cnt_d;
      mac_v_q <= (state_q == rtmu_pkg::ST_ROW);
      mac_idx_q <= cnt_q;
      if (out_ld) out_v_q <= 1'b1;
      else if (m_axis_tready) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q  <= s_axis_tdata[2:0];
      ang_q <= ANGLE_BITS'(s_axis_tdata[12:3]);
      for (int t = 0; t < 4; t++) vec_q[t] <= s_axis_tdata[13 + 32*t +: 32];
      clip_q <= 1'b0;
    end
    if (mac_v_q) begin
      res_q[mac_idx_q] <= sum_w;
      if (clip_w) clip_q <= 1'b1;
    end
    if (out_ld) out_q <= {7'd0, clip_q, res_q[3], res_q[2], res_q[1], res_q[0]};
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  `RTMU_ASSERT_IMPL(a_no_accept_busy, clk_i, rst_ni,
    (s_axis_tvalid && s_axis_tready) |-> (state_q == rtmu_pkg::ST_IDLE))
  `RTMU_ASSERT_IMPL(a_valid_hold, clk_i, rst_ni,
    (out_v_q && !m_axis_tready) |=> out_v_q)
  `RTMU_ASSERT_IMPL(a_out_hold, clk_i, rst_ni,
    (out_v_q && !m_axis_tready) |=> $stable(m_axis_tdata))

endmodule
